@@ hw/rtl/mm_pkg.sv @@
package mm_pkg;

   // Field widths fixed by the interface.
   localparam int COORD_W    = 3;
   localparam int DIM_W      = 4;
   localparam int CMD_W      = 2;
   localparam int VALUE_W    = 16;
   localparam int ACC_W      = 40;
   localparam int CSR_IDX_W  = 2;

   // Defaults for the top-level parameters.
   localparam int MAX_DIM_DEF    = 8;
   localparam int ELEM_WIDTH_DEF = 16;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_START  = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_A_ROWS    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B_COLS    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FEED,
      ST_DRAIN
   } state_type;

   // Control that travels down the cell chain with each A word.
   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last;
      logic               zero;
      logic               last_row;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] k;
   } step_type;

   // Finished dot product leaving a cell.
   typedef struct packed {
      logic               valid;
      logic               last_row;
      logic [COORD_W-1:0] row;
   } res_type;

   // Broadcast write of one B element.
   typedef struct packed {
      logic               we;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
   } bload_type;

endpackage

@@ hw/rtl/mm_cell.sv @@
module mm_cell #(
   parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
   parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF,
   parameter int CELL_COL   = 0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mm_pkg::bload_type              bload,
   input  logic signed [ELEM_WIDTH-1:0]   bload_data,
   input  mm_pkg::step_type               step_in,
   input  logic signed [ELEM_WIDTH-1:0]   a_in,
   output mm_pkg::step_type               step_out,
   output logic signed [ELEM_WIDTH-1:0]   a_out,
   output mm_pkg::res_type                res,
   output logic signed [mm_pkg::ACC_W-1:0] res_value
);

   localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int PROD_W = 2 * ELEM_WIDTH;

   // Column CELL_COL of B, one element per row.
   logic signed [ELEM_WIDTH-1:0]     b_col_ff [MAX_DIM];

   mm_pkg::step_type                 pass_ff;
   logic signed [ELEM_WIDTH-1:0]     pass_a_ff;
   mm_pkg::step_type                 prod_step_ff;
   logic signed [PROD_W-1:0]         prod_ff;
   logic signed [PROD_W-1:0]         prod_in;
   logic signed [mm_pkg::ACC_W-1:0]  acc_ff;
   logic signed [mm_pkg::ACC_W-1:0]  acc_in;
   mm_pkg::res_type                  res_ff;
   logic signed [mm_pkg::ACC_W-1:0]  res_value_ff;

   always_ff @(posedge clock) begin
      if (bload.we && (bload.col == mm_pkg::COORD_W'(CELL_COL))) begin
         b_col_ff[bload.row[IDX_W-1:0]] <= bload_data;
      end
   end

   always_comb begin
      if (step_in.zero) begin
         prod_in = '0;
      end else begin
         prod_in = PROD_W'(a_in) * PROD_W'(b_col_ff[step_in.k[IDX_W-1:0]]);
      end
   end

   always_comb begin
      if (prod_step_ff.first) begin
         acc_in = mm_pkg::ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff + mm_pkg::ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_ff      <= '0;
         prod_step_ff <= '0;
         res_ff       <= '0;
      end else begin
         pass_ff          <= step_in;
         prod_step_ff     <= step_in;
         res_ff.valid     <= prod_step_ff.valid && prod_step_ff.last;
         res_ff.last_row  <= prod_step_ff.last_row;
         res_ff.row       <= prod_step_ff.row;
      end
   end

   always_ff @(posedge clock) begin
      pass_a_ff <= a_in;
      prod_ff   <= prod_in;
      if (prod_step_ff.valid) begin
         acc_ff <= acc_in;
      end
      if (prod_step_ff.valid && prod_step_ff.last) begin
         res_value_ff <= acc_in;
      end
   end

   assign step_out  = pass_ff;
   assign a_out     = pass_a_ff;
   assign res       = res_ff;
   assign res_value = res_value_ff;

endmodule

@@ hw/rtl/mm_feeder.sv @@
module mm_feeder #(
   parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
   parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start_run,
   input  logic [mm_pkg::DIM_W-1:0]      num_rows,
   input  logic [mm_pkg::DIM_W-1:0]      num_inner,
   input  logic [mm_pkg::DIM_W-1:0]      num_cols,
   input  logic                          final_seen,
   input  logic                          a_we,
   input  logic [mm_pkg::COORD_W-1:0]    a_row,
   input  logic [mm_pkg::COORD_W-1:0]    a_col,
   input  logic signed [ELEM_WIDTH-1:0]  a_data,
   output logic                          busy,
   output mm_pkg::step_type              step_out,
   output logic signed [ELEM_WIDTH-1:0]  a_out
);

   localparam int IDX_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic signed [ELEM_WIDTH-1:0] store_a [DEPTH];

   mm_pkg::state_type            state_ff;
   mm_pkg::state_type            state_in;
   logic [IDX_W-1:0]             row_ff;
   logic [IDX_W-1:0]             step_ff;
   logic [mm_pkg::DIM_W-1:0]     period;
   logic                         step_end;
   logic                         row_end;
   logic [AW-1:0]                wr_addr;
   logic [AW-1:0]                rd_addr;
   mm_pkg::step_type             issue;
   mm_pkg::step_type             issue_ff;
   logic signed [ELEM_WIDTH-1:0] a_rd_ff;

   // Rows are spaced far enough apart that their results never overlap.
   assign period   = (num_inner > num_cols) ? num_inner : num_cols;
   assign step_end = (mm_pkg::DIM_W'(step_ff) == period - mm_pkg::DIM_W'(1));
   assign row_end  = (mm_pkg::DIM_W'(row_ff) == num_rows - mm_pkg::DIM_W'(1));
   assign wr_addr  = AW'(a_row) * AW'(MAX_DIM) + AW'(a_col);
   assign rd_addr  = AW'(row_ff) * AW'(MAX_DIM) + AW'(step_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mm_pkg::ST_IDLE: begin
            if (start_run) begin
               state_in = mm_pkg::ST_FEED;
            end
         end
         mm_pkg::ST_FEED: begin
            if (step_end && row_end) begin
               state_in = mm_pkg::ST_DRAIN;
            end
         end
         mm_pkg::ST_DRAIN: begin
            if (final_seen) begin
               state_in = mm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      issue          = '0;
      issue.row      = mm_pkg::COORD_W'(row_ff);
      issue.k        = mm_pkg::COORD_W'(step_ff);
      issue.last_row = row_end;
      case (state_ff)
         mm_pkg::ST_FEED: begin
            if (num_inner == '0) begin
               issue.valid = (step_ff == '0);
               issue.first = 1'b1;
               issue.last  = 1'b1;
               issue.zero  = 1'b1;
            end else begin
               issue.valid = (mm_pkg::DIM_W'(step_ff) < num_inner);
               issue.first = (step_ff == '0);
               issue.last  = (mm_pkg::DIM_W'(step_ff) == num_inner - mm_pkg::DIM_W'(1));
            end
         end
         default: begin
            issue.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mm_pkg::ST_IDLE;
         issue_ff <= '0;
      end else begin
         state_ff <= state_in;
         issue_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == mm_pkg::ST_IDLE) begin
         row_ff  <= '0;
         step_ff <= '0;
      end else if (state_ff == mm_pkg::ST_FEED) begin
         if (step_end) begin
            step_ff <= '0;
            row_ff  <= row_ff + IDX_W'(1);
         end else begin
            step_ff <= step_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_we) begin
         store_a[wr_addr] <= a_data;
      end
      a_rd_ff <= store_a[rd_addr];
   end

   assign busy     = (state_ff != mm_pkg::ST_IDLE);
   assign step_out = issue_ff;
   assign a_out    = a_rd_ff;

endmodule

@@ hw/rtl/matrix_multiply.sv @@
// Integer matrix multiplier, C = A x B, up to MAX_DIM x MAX_DIM.
//
// Input: a word is taken at a clock edge with start high and busy low.
// req_command selects load A element, load B element or start multiply;
// loads write one element at req_row_index / req_col_index. A load with an
// index at or above MAX_DIM is dropped; command 3 is dropped. Configuration
// (a_rows, inner_dim, b_cols, saturated to MAX_DIM) is written on the csr_
// port; the user must write it only while the block is idle (not enforced).
// Results: one word per C element in row-major order, each shown for one
// cycle with rsp_strobe high; rsp_last_result marks the final one. The
// receiver cannot stall, so results are never held back.
// The pace of a run is set by the single read port of the A memory, which
// delivers one A element per cycle to the chain. Each result passes the
// feeder's issue register, the cell's product and result registers and the
// output register.
// Busy falls in the cycle that shows the last result. A run with zero rows
// or columns gives no results and never raises busy.
// Reset clears control and sets all three dimensions to 8 (then saturated to
// MAX_DIM); A and B contents are undefined until loaded.
module matrix_multiply #(
   parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
   parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [mm_pkg::CMD_W-1:0]          req_command,
   input  logic [mm_pkg::COORD_W-1:0]        req_row_index,
   input  logic [mm_pkg::COORD_W-1:0]        req_col_index,
   input  logic signed [mm_pkg::VALUE_W-1:0] req_element_value,
   output logic                              rsp_strobe,
   output logic [mm_pkg::COORD_W-1:0]        rsp_out_row,
   output logic [mm_pkg::COORD_W-1:0]        rsp_out_col,
   output logic signed [mm_pkg::ACC_W-1:0]   rsp_product_value,
   output logic                              rsp_last_result,
   input  logic                              csr_write_enable,
   input  logic [mm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [mm_pkg::DIM_W-1:0]          csr_write_data
);

   localparam logic [mm_pkg::DIM_W-1:0] DIM_MAX = mm_pkg::DIM_W'(MAX_DIM);

   // Configuration registers, reset to the full 8 x 8 x 8 problem.
   logic [mm_pkg::DIM_W-1:0] a_rows_ff;
   logic [mm_pkg::DIM_W-1:0] inner_dim_ff;
   logic [mm_pkg::DIM_W-1:0] b_cols_ff;
   logic [mm_pkg::DIM_W-1:0] num_rows;
   logic [mm_pkg::DIM_W-1:0] num_inner;
   logic [mm_pkg::DIM_W-1:0] num_cols;

   logic                         accept;
   logic                         in_range;
   logic                         start_run;
   logic                         a_we;
   logic signed [ELEM_WIDTH-1:0] elem;
   mm_pkg::bload_type            bload;

   // Chain links: link j feeds cell j, link MAX_DIM leaves the last cell.
   mm_pkg::step_type             link_step [MAX_DIM+1];
   logic signed [ELEM_WIDTH-1:0] link_a    [MAX_DIM+1];
   mm_pkg::res_type              cell_res  [MAX_DIM];
   logic signed [mm_pkg::ACC_W-1:0] cell_value [MAX_DIM];

   logic                            sel_valid;
   logic                            sel_final;
   logic [mm_pkg::COORD_W-1:0]      sel_row;
   logic [mm_pkg::COORD_W-1:0]      sel_col;
   logic signed [mm_pkg::ACC_W-1:0] sel_value;

   logic                            rsp_strobe_ff;
   logic [mm_pkg::COORD_W-1:0]      rsp_row_ff;
   logic [mm_pkg::COORD_W-1:0]      rsp_col_ff;
   logic signed [mm_pkg::ACC_W-1:0] rsp_value_ff;
   logic                            rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_rows_ff    <= mm_pkg::DIM_W'(8);
         inner_dim_ff <= mm_pkg::DIM_W'(8);
         b_cols_ff    <= mm_pkg::DIM_W'(8);
      end else if (csr_write_enable) begin
         case (csr_index)
            mm_pkg::CSR_A_ROWS:    a_rows_ff    <= csr_write_data;
            mm_pkg::CSR_INNER_DIM: inner_dim_ff <= csr_write_data;
            mm_pkg::CSR_B_COLS:    b_cols_ff    <= csr_write_data;
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   // Saturate the dimensions to what the hardware holds.
   assign num_rows  = (a_rows_ff > DIM_MAX) ? DIM_MAX : a_rows_ff;
   assign num_inner = (inner_dim_ff > DIM_MAX) ? DIM_MAX : inner_dim_ff;
   assign num_cols  = (b_cols_ff > DIM_MAX) ? DIM_MAX : b_cols_ff;

   // Decode the accepted word.
   assign accept    = start && !busy;
   assign in_range  = (mm_pkg::DIM_W'(req_row_index) < DIM_MAX)
                   && (mm_pkg::DIM_W'(req_col_index) < DIM_MAX);
   assign elem      = ELEM_WIDTH'(req_element_value);
   assign a_we      = accept && in_range && (req_command == mm_pkg::CMD_LOAD_A);
   assign bload.we  = accept && in_range && (req_command == mm_pkg::CMD_LOAD_B);
   assign bload.row = req_row_index;
   assign bload.col = req_col_index;
   assign start_run = accept && (req_command == mm_pkg::CMD_START)
                   && (num_rows != '0) && (num_cols != '0);

   // Sequencer and A memory: issue one A element per cycle into the chain.
   mm_feeder #(
      .MAX_DIM    (MAX_DIM),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_feeder (
      .clock      (clock),
      .reset      (reset),
      .start_run  (start_run),
      .num_rows   (num_rows),
      .num_inner  (num_inner),
      .num_cols   (num_cols),
      .final_seen (sel_final),
      .a_we       (a_we),
      .a_row      (req_row_index),
      .a_col      (req_col_index),
      .a_data     (elem),
      .busy       (busy),
      .step_out   (link_step[0]),
      .a_out      (link_a[0])
   );

   // Cell j owns column j of B and accumulates C[row][j]; the A word and its
   // tags advance one cell per cycle; column j finishes the cycle after j-1.
   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      mm_cell #(
         .MAX_DIM    (MAX_DIM),
         .ELEM_WIDTH (ELEM_WIDTH),
         .CELL_COL   (j)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .bload      (bload),
         .bload_data (elem),
         .step_in    (link_step[j]),
         .a_in       (link_a[j]),
         .step_out   (link_step[j+1]),
         .a_out      (link_a[j+1]),
         .res        (cell_res[j]),
         .res_value  (cell_value[j])
      );
   end

   // At most one live cell finishes per cycle; merge them and drop the
   // columns beyond b_cols.
   always_comb begin
      sel_valid = 1'b0;
      sel_final = 1'b0;
      sel_row   = '0;
      sel_col   = '0;
      sel_value = '0;
      for (int j = 0; j < MAX_DIM; j++) begin
         if (cell_res[j].valid && (mm_pkg::DIM_W'(j) < num_cols)) begin
            sel_valid = 1'b1;
            sel_row   = cell_res[j].row;
            sel_col   = mm_pkg::COORD_W'(j);
            sel_value = cell_value[j];
            sel_final = cell_res[j].last_row
                     && (mm_pkg::DIM_W'(j) == num_cols - mm_pkg::DIM_W'(1));
         end
      end
   end

   // Output register: hold each word for exactly one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= sel_valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_row_ff   <= sel_row;
      rsp_col_ff   <= sel_col;
      rsp_value_ff <= sel_value;
      rsp_last_ff  <= sel_final;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_last_result   = rsp_last_ff;

endmodule
